### src/rccs_pkg.sv
// Package for the region-of-interest color channel sum block.
// Holds the shared types, register codes and constants; it depends on nothing.
`default_nettype none

package rccs_pkg;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned BOUND_W  = 14;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned AREA_W   = 25;
  localparam int unsigned RQ_W     = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // h/13 as (h * ROW_RECIP) >> ROW_SHIFT, exact for every 13-bit h.
  localparam logic [16:0] ROW_RECIP = 17'd80660;
  localparam int unsigned ROW_SHIFT = 20;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROI_LEFT   = 3'd0,
    CFG_ROI_TOP    = 3'd1,
    CFG_ROI_COLS   = 3'd2,
    CFG_ROI_ROWS   = 3'd3,
    CFG_BAND_MODE  = 3'd4,
    CFG_COLOR_MODE = 3'd5
  } cfg_index_t;

  // Region description prepared from the configuration registers.
  typedef struct packed {
    logic [BOUND_W-1:0] col_lo;
    logic [BOUND_W-1:0] col_hi;
    logic [BOUND_W-1:0] ra_lo;
    logic [BOUND_W-1:0] ra_hi;
    logic [BOUND_W-1:0] rb_lo;
    logic [BOUND_W-1:0] rb_hi;
    logic [AREA_W-1:0]  area;
    logic               emit;
    logic               color;
  } region_t;

  // One classified pixel, handed from the front end to the accumulator.
  typedef struct packed {
    logic [SAMPLE_W-1:0] add_b;
    logic [SAMPLE_W-1:0] add_g;
    logic [SAMPLE_W-1:0] add_r;
    logic                last;
    logic                emit;
    logic                color;
    logic [AREA_W-1:0]   area;
  } entry_t;

endpackage

`default_nettype wire

### src/rccs_cfg.sv
// Configuration registers and the region bounds and area derived from them.
// Depends on rccs_pkg.
`default_nettype none

module rccs_cfg #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [rccs_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [rccs_pkg::CFG_DATA_W-1:0]    wr_data,
  output rccs_pkg::region_t                       region
);

  logic [rccs_pkg::COORD_W-1:0] roi_left;
  logic [rccs_pkg::COORD_W-1:0] roi_top;
  logic [rccs_pkg::DIM_W-1:0]   roi_cols;
  logic [rccs_pkg::DIM_W-1:0]   roi_rows;
  logic                         band_mode;
  logic                         color_mode;
  logic [rccs_pkg::RQ_W-1:0]    row_q;

  logic [rccs_pkg::DIM_W-1:0]   dim_clamped;
  logic [29:0]                  rq_prod;
  logic [10:0]                  col_q;
  logic [10:0]                  rq3;
  logic [11:0]                  rq6;
  logic [12:0]                  rq9;
  logic [10:0]                  rq5;
  logic [rccs_pkg::DIM_W-1:0]   area_a;
  logic [rccs_pkg::DIM_W-1:0]   area_b;
  logic [rccs_pkg::BOUND_W-1:0] left_x;
  logic [rccs_pkg::BOUND_W-1:0] top_x;
  rccs_pkg::region_t            region_next;

  assign dim_clamped = (wr_data > rccs_pkg::DIM_W'(MAX_DIM)) ?
                       rccs_pkg::DIM_W'(MAX_DIM) : wr_data;
  // Row thirteenth of the band split, h/13, by reciprocal multiplication.
  assign rq_prod = 30'(dim_clamped) * 30'(rccs_pkg::ROW_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left   <= '0;
      roi_top    <= '0;
      roi_cols   <= '0;
      roi_rows   <= '0;
      band_mode  <= 1'b0;
      color_mode <= 1'b1;
      row_q      <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        rccs_pkg::CFG_ROI_LEFT:   roi_left <= wr_data[rccs_pkg::COORD_W-1:0];
        rccs_pkg::CFG_ROI_TOP:    roi_top  <= wr_data[rccs_pkg::COORD_W-1:0];
        rccs_pkg::CFG_ROI_COLS:   roi_cols <= dim_clamped;
        rccs_pkg::CFG_ROI_ROWS: begin
          roi_rows <= dim_clamped;
          row_q    <= rq_prod[rccs_pkg::ROW_SHIFT +: rccs_pkg::RQ_W];
        end
        rccs_pkg::CFG_BAND_MODE:  band_mode  <= wr_data[0];
        rccs_pkg::CFG_COLOR_MODE: color_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign col_q  = roi_cols[12:2];
  assign rq3    = {1'b0, row_q, 1'b0} + 11'(row_q);
  assign rq6    = {rq3, 1'b0};
  assign rq9    = 13'(rq6) + 13'(rq3);
  assign rq5    = {row_q, 2'b00} + 11'(row_q);
  assign left_x = rccs_pkg::BOUND_W'(roi_left);
  assign top_x  = rccs_pkg::BOUND_W'(roi_top);

  always_comb begin
    region_next = '0;
    region_next.emit  = (roi_cols != '0) && (roi_rows != '0);
    region_next.color = color_mode;
    if (band_mode) begin
      region_next.col_lo = left_x + rccs_pkg::BOUND_W'(col_q);
      region_next.col_hi = left_x + rccs_pkg::BOUND_W'(roi_cols)
                           - rccs_pkg::BOUND_W'(col_q);
      region_next.ra_lo  = top_x + rccs_pkg::BOUND_W'(row_q);
      region_next.ra_hi  = top_x + rccs_pkg::BOUND_W'(rq3);
      region_next.rb_lo  = top_x + rccs_pkg::BOUND_W'(rq6);
      region_next.rb_hi  = top_x + rccs_pkg::BOUND_W'(rq9);
      area_a = roi_cols - {col_q, 1'b0};
      area_b = rccs_pkg::DIM_W'(rq5);
    end else begin
      // The second band is empty: its lower and upper bounds coincide.
      region_next.col_lo = left_x;
      region_next.col_hi = left_x + rccs_pkg::BOUND_W'(roi_cols);
      region_next.ra_lo  = top_x;
      region_next.ra_hi  = top_x + rccs_pkg::BOUND_W'(roi_rows);
      region_next.rb_lo  = '0;
      region_next.rb_hi  = '0;
      area_a = roi_cols;
      area_b = roi_rows;
    end
    region_next.area = rccs_pkg::AREA_W'(26'(area_a) * 26'(area_b));
  end

  always_ff @(posedge clk) begin
    region <= region_next;
  end

endmodule

`default_nettype wire

### src/rccs_front.sv
// Front end: input register and region test that turns a pixel into a queue entry.
// Depends on rccs_pkg.
`default_nettype none

module rccs_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rccs_pkg::COORD_W-1:0]      pixel_col,
  input  wire logic [rccs_pkg::COORD_W-1:0]      pixel_row,
  input  wire logic [rccs_pkg::SAMPLE_W-1:0]     blue_sample,
  input  wire logic [rccs_pkg::SAMPLE_W-1:0]     green_sample,
  input  wire logic [rccs_pkg::SAMPLE_W-1:0]     red_sample,
  input  wire logic                              frame_end,
  input  wire rccs_pkg::region_t                 region,
  output logic                                   push,
  output rccs_pkg::entry_t                       push_entry,
  input  wire logic                              queue_full
);

  logic                          s1_valid;
  logic [rccs_pkg::COORD_W-1:0]  s1_col;
  logic [rccs_pkg::COORD_W-1:0]  s1_row;
  logic [rccs_pkg::SAMPLE_W-1:0] s1_b;
  logic [rccs_pkg::SAMPLE_W-1:0] s1_g;
  logic [rccs_pkg::SAMPLE_W-1:0] s1_r;
  logic                          s1_last;
  logic [rccs_pkg::BOUND_W-1:0]  col_x;
  logic [rccs_pkg::BOUND_W-1:0]  row_x;
  logic                          col_ok;
  logic                          band_a;
  logic                          band_b;
  logic                          hit;

  assign push     = s1_valid && !queue_full;
  assign in_ready = !s1_valid || !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_col  <= pixel_col;
      s1_row  <= pixel_row;
      s1_b    <= blue_sample;
      s1_g    <= green_sample;
      s1_r    <= red_sample;
      s1_last <= frame_end;
    end
  end

  assign col_x  = rccs_pkg::BOUND_W'(s1_col);
  assign row_x  = rccs_pkg::BOUND_W'(s1_row);
  assign col_ok = (col_x >= region.col_lo) && (col_x < region.col_hi);
  assign band_a = (row_x >= region.ra_lo) && (row_x < region.ra_hi);
  assign band_b = (row_x >= region.rb_lo) && (row_x < region.rb_hi);
  assign hit    = col_ok && (band_a || band_b);

  always_comb begin
    push_entry.add_g = hit ? s1_g : '0;
    push_entry.add_b = (hit && region.color) ? s1_b : '0;
    push_entry.add_r = (hit && region.color) ? s1_r : '0;
    push_entry.last  = s1_last;
    push_entry.emit  = region.emit;
    push_entry.color = region.color;
    push_entry.area  = region.area;
  end

endmodule

`default_nettype wire

### src/rccs_queue.sv
// Short queue of classified pixels between the front end and the accumulator.
// Depends on rccs_pkg.
`default_nettype none

module rccs_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rccs_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output rccs_pkg::entry_t      head
);

  rccs_pkg::entry_t              slots [rccs_pkg::QUEUE_DEPTH];
  logic [rccs_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rccs_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rccs_pkg::QPTR_W:0]     count;

  assign full  = (count == (rccs_pkg::QPTR_W+1)'(rccs_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### src/rccs_back.sv
// Back end: channel accumulators and the registered result stage.
// Depends on rccs_pkg.
`default_nettype none

module rccs_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           empty,
  input  wire rccs_pkg::entry_t               head,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rccs_pkg::SUM_W-1:0]          red_sum,
  output logic [rccs_pkg::SUM_W-1:0]          green_sum,
  output logic [rccs_pkg::SUM_W-1:0]          blue_sum,
  output logic [rccs_pkg::AREA_W-1:0]         pixel_area,
  output logic                                three_channel
);

  logic [rccs_pkg::SUM_W-1:0] red_acc;
  logic [rccs_pkg::SUM_W-1:0] green_acc;
  logic [rccs_pkg::SUM_W-1:0] blue_acc;
  logic [rccs_pkg::SUM_W-1:0] red_acc_next;
  logic [rccs_pkg::SUM_W-1:0] green_acc_next;
  logic [rccs_pkg::SUM_W-1:0] blue_acc_next;
  logic                       report;

  assign red_acc_next   = red_acc + rccs_pkg::SUM_W'(head.add_r);
  assign green_acc_next = green_acc + rccs_pkg::SUM_W'(head.add_g);
  assign blue_acc_next  = blue_acc + rccs_pkg::SUM_W'(head.add_b);

  // An entry that produces a result waits only while the result stage is held.
  assign report = head.last && head.emit;
  assign pop    = !empty && (!report || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_acc   <= '0;
      green_acc <= '0;
      blue_acc  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          red_acc   <= '0;
          green_acc <= '0;
          blue_acc  <= '0;
        end else begin
          red_acc   <= red_acc_next;
          green_acc <= green_acc_next;
          blue_acc  <= blue_acc_next;
        end
      end
      if (pop && report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && report) begin
      red_sum       <= head.color ? red_acc_next : '0;
      green_sum     <= green_acc_next;
      blue_sum      <= head.color ? blue_acc_next : '0;
      pixel_area    <= head.area;
      three_channel <= head.color;
    end
  end

endmodule

`default_nettype wire

### src/roi_color_channel_sum.sv
// Top level of the region-of-interest color channel sum block.
// Depends on rccs_pkg, rccs_cfg, rccs_front, rccs_queue and rccs_back.
`default_nettype none

// The block sums the blue, green and red samples of every pixel that falls in
// a configured rectangle, or in two horizontal face bands cut from it when
// band_mode is set, and reports the three sums with the region's area on the
// pixel marked frame_end. It takes one pixel transaction per clock without
// gaps; the only thing that stops it is a result transaction held by the
// consumer, which backs up a four-entry queue and then the input register.
// A pixel's result reaches the output register through the input register
// and the queue. The front end registers the pixel and tests it against
// bounds prepared from the configuration; the back end adds it into the
// accumulators and loads the output register at the frame's end. In gray mode
// (color_mode clear) the gray value travels on green_sample into green_sum,
// and red_sum and blue_sum read zero. A frame whose rectangle has zero width
// or height gives no result, but its sums are still cleared. Configuration
// writes are always accepted (cfg_ready is tied high) and must be made while
// no pixel is in flight; the division of the height by 13 happens at the
// write, and the prepared bounds and area follow in the next cycle. Width and
// height above MAX_DIM are clamped on the write.
module roi_color_channel_sum #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rccs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rccs_pkg::COORD_W-1:0]    pixel_col,
  input  wire logic [rccs_pkg::COORD_W-1:0]    pixel_row,
  input  wire logic [rccs_pkg::SAMPLE_W-1:0]   blue_sample,
  input  wire logic [rccs_pkg::SAMPLE_W-1:0]   green_sample,
  input  wire logic [rccs_pkg::SAMPLE_W-1:0]   red_sample,
  input  wire logic                            frame_end,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rccs_pkg::SUM_W-1:0]           red_sum,
  output logic [rccs_pkg::SUM_W-1:0]           green_sum,
  output logic [rccs_pkg::SUM_W-1:0]           blue_sum,
  output logic [rccs_pkg::AREA_W-1:0]          pixel_area,
  output logic                                 three_channel
);

  rccs_pkg::region_t region;
  rccs_pkg::entry_t  push_entry;
  rccs_pkg::entry_t  head;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  rccs_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .region   (region)
  );

  // Front end: captures the pixel, tests it against the region and masks
  // the samples that do not count.
  rccs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .blue_sample  (blue_sample),
    .green_sample (green_sample),
    .red_sample   (red_sample),
    .frame_end    (frame_end),
    .region       (region),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (queue_full)
  );

  rccs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .head       (head)
  );

  // Back end: accumulates and hands out one result transaction per frame with a non-empty rectangle.
  rccs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red_sum       (red_sum),
    .green_sum     (green_sum),
    .blue_sum      (blue_sum),
    .pixel_area    (pixel_area),
    .three_channel (three_channel)
  );

endmodule

`default_nettype wire

### src/rccs_checker.sv
// Port-level checks for roi_color_channel_sum, bound to the top level.
// Depends on rccs_pkg.
`default_nettype none

module rccs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rccs_pkg::SUM_W-1:0]    red_sum,
  input wire logic [rccs_pkg::SUM_W-1:0]    green_sum,
  input wire logic [rccs_pkg::SUM_W-1:0]    blue_sum,
  input wire logic [rccs_pkg::AREA_W-1:0]   pixel_area,
  input wire logic                          three_channel
);

  // A held result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A held result transaction keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_sum) && $stable(green_sum) &&
      $stable(blue_sum) && $stable(pixel_area) && $stable(three_channel))
    else $error("result payload changed while stalled");

  // Gray results carry nothing on the red and blue sums.
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !three_channel |-> red_sum == '0 && blue_sum == '0)
    else $error("gray result with nonzero red or blue sum");

  // The clamped rectangle never exceeds 4096 by 4096 pixels.
  a_area_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_area <= 25'd16777216)
    else $error("area out of range");

endmodule

bind roi_color_channel_sum rccs_checker u_rccs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .red_sum       (red_sum),
  .green_sum     (green_sum),
  .blue_sum      (blue_sum),
  .pixel_area    (pixel_area),
  .three_channel (three_channel)
);

`default_nettype wire

### tb/sv/roi_color_channel_sum_test.sv
// Self-checking testbench for roi_color_channel_sum: a scripted pixel table, then random frames.
// Depends on rccs_pkg and the roi_color_channel_sum RTL only.
`default_nettype none

module roi_color_channel_sum_test;

  // The block default; widths and heights above it saturate on the write.
  localparam int unsigned DIM_LIMIT = 4096;

  // Geometry of the face bands: columns lose a quarter of the width on each
  // side, rows are cut in thirteenths, and the bands span 1..3 and 6..9.
  localparam int unsigned COL_PARTS    = 4;
  localparam int unsigned ROW_PARTS    = 13;
  localparam int unsigned BAND_A_END   = 3;
  localparam int unsigned BAND_B_START = 6;
  localparam int unsigned BAND_B_END   = 9;
  localparam int unsigned BAND_ROWS    = 5;

  // Index values that the register map leaves unused; writes to them must be ignored.
  localparam logic [rccs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [rccs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // Cycles for a pixel to run through the front end, the queue and the back end.
  localparam int DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_PIXELS = 1000;

  // How a scripted pixel transaction is checked: by the predictor, against a
  // typed-in result, or as a frame end that must stay silent.
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_TYPED,
    CHECK_NONE
  } check_kind_t;

  typedef struct packed {
    logic [rccs_pkg::SUM_W-1:0]  red;
    logic [rccs_pkg::SUM_W-1:0]  green;
    logic [rccs_pkg::SUM_W-1:0]  blue;
    logic [rccs_pkg::AREA_W-1:0] area;
    logic                        color;
  } sums_t;

  // Raw register data, written as it stands; masking and clamping are the block's job.
  typedef struct packed {
    logic [rccs_pkg::CFG_DATA_W-1:0] left;
    logic [rccs_pkg::CFG_DATA_W-1:0] top;
    logic [rccs_pkg::CFG_DATA_W-1:0] cols;
    logic [rccs_pkg::CFG_DATA_W-1:0] rows;
    logic [rccs_pkg::CFG_DATA_W-1:0] band;
    logic [rccs_pkg::CFG_DATA_W-1:0] color;
  } region_setting_t;

  typedef struct packed {
    logic [3:0]                    setting;
    logic [rccs_pkg::COORD_W-1:0]  col;
    logic [rccs_pkg::COORD_W-1:0]  row;
    logic [rccs_pkg::SAMPLE_W-1:0] blue;
    logic [rccs_pkg::SAMPLE_W-1:0] green;
    logic [rccs_pkg::SAMPLE_W-1:0] red;
    logic                          last;
    check_kind_t                   check;
    sums_t                         typed;
  } script_row_t;

  localparam logic [3:0] KEEP = 4'd0;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rccs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rccs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [rccs_pkg::COORD_W-1:0]    pixel_col = '0;
  logic [rccs_pkg::COORD_W-1:0]    pixel_row = '0;
  logic [rccs_pkg::SAMPLE_W-1:0]   blue_sample = '0;
  logic [rccs_pkg::SAMPLE_W-1:0]   green_sample = '0;
  logic [rccs_pkg::SAMPLE_W-1:0]   red_sample = '0;
  logic                            frame_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [rccs_pkg::SUM_W-1:0]      red_sum;
  logic [rccs_pkg::SUM_W-1:0]      green_sum;
  logic [rccs_pkg::SUM_W-1:0]      blue_sum;
  logic [rccs_pkg::AREA_W-1:0]     pixel_area;
  logic                            three_channel;

  // Travel with the pixel payload, so the monitor knows how to check it.
  check_kind_t pixel_check = CHECK_MODEL;
  sums_t       pixel_typed = '0;

  int send_idle_pct = 0;
  int hold_pct = 0;
  int pixels_sent = 0;
  int mismatches = 0;
  int unsigned cycles = 0;

  // Predictor copy of the registers and the running sums.
  logic [rccs_pkg::COORD_W-1:0] cur_left = '0;
  logic [rccs_pkg::COORD_W-1:0] cur_top = '0;
  logic [rccs_pkg::DIM_W-1:0]   cur_cols = '0;
  logic [rccs_pkg::DIM_W-1:0]   cur_rows = '0;
  logic                         cur_band = 1'b0;
  logic                         cur_color = 1'b1;
  logic [rccs_pkg::SUM_W-1:0]   acc_red = '0;
  logic [rccs_pkg::SUM_W-1:0]   acc_green = '0;
  logic [rccs_pkg::SUM_W-1:0]   acc_blue = '0;

  sums_t pending_sums[$];

  // Register settings used by the script; entry 0 stands for "keep what is there".
  // Entry 1 writes the full 4096 by 4096 image, with bit 12 set on the left
  // and top data (it must be dropped) and both sizes above the limit.
  region_setting_t settings [0:6] = '{
    '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd1},
    '{13'h1000, 13'h1000, 13'd8191, 13'd4097, 13'd0, 13'd1},
    '{13'd0, 13'd0, 13'd4096, 13'd4096, 13'd0, 13'd0},
    '{13'd4095, 13'd4095, 13'd1, 13'd1, 13'd0, 13'd1},
    '{13'd100, 13'd200, 13'd40, 13'd26, 13'd1, 13'd1},
    '{13'd100, 13'd200, 13'd40, 13'd26, 13'd0, 13'd0},
    '{13'd0, 13'd0, 13'd0, 13'd4096, 13'd0, 13'd1}
  };

  // The band setting (entry 4) keeps columns 110..129 and rows 202..205 and
  // 212..217, so its area is 20 * 10. The rows around it probe each border.
  script_row_t script [0:22] = '{
    // Out of reset the rectangle is empty: the frame end stays silent.
    '{KEEP, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1, CHECK_NONE, '0},
    // Whole image, both corners at full scale.
    '{4'd1, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1, CHECK_TYPED,
      '{32'd510, 32'd510, 32'd510, 25'd16777216, 1'b1}},
    // Gray mode: only the gray value counts, red and blue read zero.
    '{4'd2, 12'd10, 12'd10, 8'd1, 8'd200, 8'd3, 1'b1, CHECK_TYPED,
      '{32'd0, 32'd200, 32'd0, 25'd16777216, 1'b0}},
    // One-pixel rectangle in the far corner.
    '{4'd3, 12'd4095, 12'd4095, 8'h55, 8'hAA, 8'h0F, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd4094, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd4095, 12'd4094, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd0, 12'd0, 8'd1, 8'd2, 8'd3, 1'b1, CHECK_TYPED,
      '{32'd15, 32'd170, 32'd85, 25'd1, 1'b1}},
    // Face bands.
    '{4'd4, 12'd110, 12'd202, 8'd10, 8'd20, 8'd30, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd129, 12'd205, 8'd1, 8'd2, 8'd3, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd109, 12'd202, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd130, 12'd202, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd110, 12'd201, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd110, 12'd206, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd110, 12'd211, 8'd255, 8'd255, 8'd255, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd110, 12'd212, 8'd4, 8'd5, 8'd6, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd129, 12'd217, 8'd7, 8'd8, 8'd9, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd120, 12'd218, 8'd255, 8'd255, 8'd255, 1'b1, CHECK_MODEL, '0},
    // Modes change in the middle of a frame: the first pixel is summed as
    // color bands, the rest as a gray rectangle.
    '{4'd4, 12'd120, 12'd203, 8'd50, 8'd60, 8'd70, 1'b0, CHECK_MODEL, '0},
    '{4'd5, 12'd100, 12'd200, 8'd11, 8'd22, 8'd33, 1'b0, CHECK_MODEL, '0},
    '{KEEP, 12'd139, 12'd225, 8'd1, 8'd1, 8'd1, 1'b1, CHECK_MODEL, '0},
    '{KEEP, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1, CHECK_MODEL, '0},
    // Zero width with a full height still gives no result.
    '{4'd6, 12'd0, 12'd0, 8'd9, 8'd9, 8'd9, 1'b1, CHECK_NONE, '0}
  };

  roi_color_channel_sum #(
    .MAX_DIM(DIM_LIMIT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .blue_sample  (blue_sample),
    .green_sample (green_sample),
    .red_sample   (red_sample),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_sum      (red_sum),
    .green_sum    (green_sum),
    .blue_sum     (blue_sum),
    .pixel_area   (pixel_area),
    .three_channel(three_channel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Register write as the block sees it: left and top keep 12 bits, the sizes
  // saturate at the limit, the mode bits keep bit 0, spare indexes do nothing.
  task automatic store_register(input logic [rccs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rccs_pkg::CFG_DATA_W-1:0] data);
    case (rccs_pkg::cfg_index_t'(idx))
      rccs_pkg::CFG_ROI_LEFT:   cur_left = data[rccs_pkg::COORD_W-1:0];
      rccs_pkg::CFG_ROI_TOP:    cur_top = data[rccs_pkg::COORD_W-1:0];
      rccs_pkg::CFG_ROI_COLS:
        cur_cols = (data > DIM_LIMIT) ? rccs_pkg::DIM_W'(DIM_LIMIT) : data;
      rccs_pkg::CFG_ROI_ROWS:
        cur_rows = (data > DIM_LIMIT) ? rccs_pkg::DIM_W'(DIM_LIMIT) : data;
      rccs_pkg::CFG_BAND_MODE:  cur_band = data[0];
      rccs_pkg::CFG_COLOR_MODE: cur_color = data[0];
      default: ;
    endcase
  endtask

  // Adds one pixel into the running sums under the registers that hold now,
  // and on the frame end produces the result (if the rectangle is not empty)
  // and clears the sums. All bounds are compared in 32 bits, so a rectangle
  // reaching past column or row 4095 needs no special handling.
  task automatic accumulate_pixel(input logic [rccs_pkg::COORD_W-1:0] col, row,
                                  input logic [rccs_pkg::SAMPLE_W-1:0] b, g, r,
                                  input logic last,
                                  output bit produced, output sums_t res);
    int unsigned c, rw, w, h, cq, rq, area;
    bit hit;
    c = col;
    rw = row;
    w = cur_cols;
    h = cur_rows;
    cq = w / COL_PARTS;
    rq = h / ROW_PARTS;
    if (!cur_band) begin
      hit = c >= cur_left && c < cur_left + w && rw >= cur_top && rw < cur_top + h;
      area = w * h;
    end else begin
      hit = c >= cur_left + cq && c < cur_left + w - cq &&
            ((rw >= cur_top + rq && rw < cur_top + BAND_A_END * rq) ||
             (rw >= cur_top + BAND_B_START * rq && rw < cur_top + BAND_B_END * rq));
      area = (w - 2 * cq) * (BAND_ROWS * rq);
    end
    if (hit) begin
      acc_green += g;
      if (cur_color) begin
        acc_blue += b;
        acc_red += r;
      end
    end
    produced = 1'b0;
    res = '0;
    if (last) begin
      if (w != 0 && h != 0) begin
        produced = 1'b1;
        res.red = cur_color ? acc_red : '0;
        res.green = acc_green;
        res.blue = cur_color ? acc_blue : '0;
        res.area = area[rccs_pkg::AREA_W-1:0];
        res.color = cur_color;
      end
      acc_red = '0;
      acc_green = '0;
      acc_blue = '0;
    end
  endtask

  task automatic compare_field(input string name,
                               input logic [rccs_pkg::SUM_W-1:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor. Everything is sampled at the rising edge, before the NBA updates
  // of that edge land, so the testbench and the block see the same values.
  // The result check runs before the prediction, so a stray result cannot
  // be matched against an expectation pushed at the same edge.
  always @(posedge clk) begin : monitor
    sums_t predicted;
    sums_t want;
    bit produced;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual red %0d green %0d blue %0d",
                   $time, red_sum, green_sum, blue_sum);
          mismatches++;
        end else begin
          want = pending_sums.pop_front();
          compare_field("red_sum", want.red, red_sum);
          compare_field("green_sum", want.green, green_sum);
          compare_field("blue_sum", want.blue, blue_sum);
          compare_field("pixel_area", rccs_pkg::SUM_W'(want.area),
                        rccs_pkg::SUM_W'(pixel_area));
          compare_field("three_channel", rccs_pkg::SUM_W'(want.color),
                        rccs_pkg::SUM_W'(three_channel));
        end
      end
      if (cfg_valid && cfg_ready) begin
        store_register(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        accumulate_pixel(pixel_col, pixel_row, blue_sample, green_sample, red_sample,
                         frame_end, produced, predicted);
        case (pixel_check)
          CHECK_TYPED: pending_sums.push_back(pixel_typed);
          CHECK_MODEL: if (produced) pending_sums.push_back(predicted);
          default: ;
        endcase
      end
    end
  end

  // Result consumer: stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= hold_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("roi_color_channel_sum verification failed");
      $finish;
    end
  end

  // Offers one pixel transaction after a random number of idle cycles and
  // returns at the edge where it is accepted. Valid is left high, so
  // back-to-back pixels keep it up without a gap.
  task automatic send_pixel(input logic [rccs_pkg::COORD_W-1:0] col, row,
                            input logic [rccs_pkg::SAMPLE_W-1:0] b, g, r,
                            input logic last, input check_kind_t check,
                            input sums_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    blue_sample <= b;
    green_sample <= g;
    red_sample <= r;
    frame_end <= last;
    pixel_check <= check;
    pixel_typed <= typed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Holds the sender until every expected result has been taken, then lets
  // result-less pixels still in the pipeline run out. Checking on the falling
  // edge keeps clear of the monitor's updates at the rising one.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [rccs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rccs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all six registers with the block idle; optionally also pokes one
  // of the unused indexes. Valid drops only after the last write.
  task automatic apply_setting(input region_setting_t s, input bit with_spare);
    wait_drained();
    write_register(rccs_pkg::CFG_ROI_LEFT, s.left);
    write_register(rccs_pkg::CFG_ROI_TOP, s.top);
    write_register(rccs_pkg::CFG_ROI_COLS, s.cols);
    write_register(rccs_pkg::CFG_ROI_ROWS, s.rows);
    write_register(rccs_pkg::CFG_BAND_MODE, s.band);
    write_register(rccs_pkg::CFG_COLOR_MODE, s.color);
    if (with_spare) begin
      write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                     rccs_pkg::CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly modest sizes so the bands and borders get hit; now and then empty,
  // one pixel, the full limit, or oversized data that must saturate.
  function automatic logic [rccs_pkg::CFG_DATA_W-1:0] random_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return rccs_pkg::CFG_DATA_W'(1);
      2:       return rccs_pkg::CFG_DATA_W'(DIM_LIMIT);
      3:       return rccs_pkg::CFG_DATA_W'($urandom_range(DIM_LIMIT + 1, 8191));
      4, 5:    return rccs_pkg::CFG_DATA_W'($urandom_range(2, 12));
      default: return rccs_pkg::CFG_DATA_W'($urandom_range(13, 80));
    endcase
  endfunction

  // A coordinate near the rectangle, covering its border on both sides; one
  // in eight is anywhere in the image.
  function automatic logic [rccs_pkg::COORD_W-1:0] near_coord(input int unsigned base,
                                                              span);
    int v;
    if ($urandom_range(0, 7) == 0) return rccs_pkg::COORD_W'($urandom);
    v = int'(base) + int'($urandom_range(0, span + 3)) - 2;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return rccs_pkg::COORD_W'(v);
  endfunction

  initial begin : stimulus
    region_setting_t setting;
    int frames, len, phase;
    logic last;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Scripted part, with no idling on either side.
    foreach (script[i]) begin
      if (script[i].setting != KEEP) apply_setting(settings[script[i].setting], 1'b0);
      send_pixel(script[i].col, script[i].row, script[i].blue, script[i].green,
                 script[i].red, script[i].last, script[i].check, script[i].typed);
    end

    // Random part. Each phase takes a new register setting and an idling
    // pattern, then sends whole frames with random content. The last frame of
    // a phase is sometimes left open, so its sums carry over into the next
    // setting, the way a mode change in the middle of a frame behaves.
    phase = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          hold_pct <= 0;
        end
        1: begin
          send_idle_pct = 86;
          hold_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          hold_pct <= 86;
        end
        default: begin
          send_idle_pct = 23;
          hold_pct <= 23;
        end
      endcase
      setting.left = rccs_pkg::CFG_DATA_W'($urandom);
      setting.top = rccs_pkg::CFG_DATA_W'($urandom);
      setting.cols = random_dim();
      setting.rows = random_dim();
      setting.band = rccs_pkg::CFG_DATA_W'($urandom);
      setting.color = rccs_pkg::CFG_DATA_W'($urandom);
      apply_setting(setting, 1'b1);
      frames = $urandom_range(3, 8);
      for (int f = 0; f < frames; f++) begin
        len = $urandom_range(1, 16);
        for (int p = 0; p < len; p++) begin
          last = (p == len - 1) && !(f == frames - 1 && $urandom_range(0, 2) == 0);
          send_pixel(near_coord(cur_left, cur_cols), near_coord(cur_top, cur_rows),
                     rccs_pkg::SAMPLE_W'($urandom), rccs_pkg::SAMPLE_W'($urandom),
                     rccs_pkg::SAMPLE_W'($urandom), last, CHECK_MODEL, '0);
        end
        // Once in a while the sender holds off mid-phase until the consumer
        // has caught up completely.
        if (phase % 8 == 1 && f == frames / 2) wait_drained();
      end
      phase++;
    end

    wait_drained();
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("roi_color_channel_sum verification clean");
    end else begin
      $display("roi_color_channel_sum verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
